// ===== hw/rtl/lphs_pkg.sv =====
// ----------------------------------------------------------------------------
// lphs_pkg
// Types and constants shared by the linear probe hash set modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lphs_pkg;

  // Operation codes of an input item. Code three acts as a membership test.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;

  // Modulus register limits and reset value.
  localparam logic [10:0] MIN_SLOTS   = 11'd3;
  localparam logic [10:0] SLOTS_RESET = 11'd769;

  // Remainder bits resolved by the modulo unit in one cycle.
  localparam int unsigned MOD_BITS_PER_STEP = 4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key;
  } in_item_t;

  typedef struct packed {
    logic        present;
    logic [2:0]  status;
    logic [10:0] occupancy;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RMOD,
    S_PLACE_RD,
    S_PLACE_CHK,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lphs_mod.sv =====
// ----------------------------------------------------------------------------
// lphs_mod
// Iterative 64-bit by 11-bit remainder unit, a few bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_mod (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [10:0] divisor,
  output logic             done,
  output logic [10:0]      remainder
);
  import lphs_pkg::*;

  localparam int unsigned STEPS = 64 / MOD_BITS_PER_STEP;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [63:0]      dvd;
  logic [11:0]      rem;
  logic [10:0]      dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [11:0]      rem_next;

  // Restoring remainder steps, most significant dividend bits first.
  always_comb begin
    rem_next = rem;
    for (int i = 0; i < MOD_BITS_PER_STEP; i++) begin
      rem_next = {rem_next[10:0], dvd[63 - i]};
      if (rem_next >= {1'b0, dsr}) begin
        rem_next = rem_next - {1'b0, dsr};
      end
    end
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      dvd  <= dvd << MOD_BITS_PER_STEP;
      cnt  <= cnt + 1'b1;
      if (cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign remainder = rem[10:0];

endmodule

`default_nettype wire

// ===== hw/rtl/lphs_store.sv =====
// ----------------------------------------------------------------------------
// lphs_store
// Key table: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [63:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [63:0]        rdata
);

  logic [63:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/linear_probe_hash_set_top.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_set_top
// Hash set of nonzero 64-bit keys in an open-addressed, linearly probed table.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries an operation (add, remove, test) and a
// key; each produces exactly one output transfer with present, status and
// occupancy. One item is worked at a time and in_ready is high only while
// the sequencer is idle. A zero key skips the modulo unit and goes straight
// to loading its result. Any other key first passes through the shared
// modulo unit (16 steps of four remainder bits, then the remainder is handed
// over), then reads its probed slots one at a time, since every slot read
// goes through the table's single registered read port, and then its result
// is loaded. A remove also rescans the rest of the cluster, reading each key,
// and sends each moved key through the modulo unit and its probes again to
// reinsert it.
// A write on the cfg channel sets the modulus and empties the set; it is
// taken only while no item is in flight. Reset does the same with modulus
// 769. Either starts a clearing pass over all TABLE_DEPTH slots with no item taken.
// The result sits in an output register; when the receiver stalls, the next
// item is still accepted, and its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_set_top #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lphs_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lphs_pkg::out_item_t     out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [10:0]        cfg_data
);
  import lphs_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [10:0] MCAP = 11'(TABLE_DEPTH < 2047 ? TABLE_DEPTH : 2047);

  state_t        state, state_next;
  logic [10:0]   slots;
  logic [10:0]   m;
  logic [AW-1:0] clr;
  logic [1:0]    op, op_next;
  logic [63:0]   key, key_next;
  logic [63:0]   rkey, rkey_next;
  logic [AW-1:0] pos, pos_next;
  logic [AW-1:0] sp, sp_next;
  logic [10:0]   n, n_next;
  logic [10:0]   count, count_next;
  logic          res_present, res_present_next;
  logic [2:0]    res_status, res_status_next;
  logic          out_load;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   rd_data;

  logic          mod_start;
  logic [63:0]   mod_dvd;
  logic          mod_done;
  logic [10:0]   mod_rem;

  logic [AW-1:0] pos_inc, sp_inc;
  logic          last_probe;

  // Effective modulus, clamped to the usable range.
  always_comb begin
    if (slots < MIN_SLOTS) begin
      m = MIN_SLOTS;
    end else if (slots > MCAP) begin
      m = MCAP;
    end else begin
      m = slots;
    end
  end

  // Probe steps wrap at the modulus.
  assign pos_inc    = ((AW+1)'(pos) + 1'b1 == (AW+1)'(m)) ? '0 : pos + 1'b1;
  assign sp_inc     = ((AW+1)'(sp) + 1'b1 == (AW+1)'(m)) ? '0 : sp + 1'b1;
  assign last_probe = (n + 1'b1 == m);

  // A register write has priority over a new item and only lands between items.
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);
  assign mem_raddr = (state == S_SCAN_RD) ? sp : pos;
  assign mod_dvd   = (state == S_IDLE) ? in_item.key : rd_data;
  assign out_load  = (state == S_FIN) && (!out_valid || out_ready);

  lphs_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_dvd),
    .divisor   (m),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  lphs_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Sequencer: next state, datapath updates and table writes.
  always_comb begin
    state_next       = state;
    op_next          = op;
    key_next         = key;
    rkey_next        = rkey;
    pos_next         = pos;
    sp_next          = sp;
    n_next           = n;
    count_next       = count;
    res_present_next = res_present;
    res_status_next  = res_status;
    mem_we           = 1'b0;
    mem_waddr        = pos;
    mem_wdata        = '0;
    mod_start        = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        if (clr == AW'(TABLE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op_next          = in_item.operation;
          key_next         = in_item.key;
          res_present_next = 1'b0;
          res_status_next  = ST_OK;
          if (in_item.key == '0) begin
            res_status_next = ST_ZERO;
            state_next      = S_FIN;
          end else begin
            mod_start  = 1'b1;
            state_next = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          pos_next   = AW'(mod_rem);
          n_next     = '0;
          state_next = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        state_next = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (rd_data == key) begin
          // Key found.
          case (op)
            OP_ADD: begin
              res_present_next = 1'b1;
              res_status_next  = ST_DUP;
              state_next       = S_FIN;
            end
            OP_REMOVE: begin
              mem_we     = 1'b1;
              count_next = (count != '0) ? count - 1'b1 : count;
              sp_next    = pos_inc;
              n_next     = 11'd1;
              state_next = S_SCAN_RD;
            end
            default: begin
              res_present_next = 1'b1;
              state_next       = S_FIN;
            end
          endcase
        end else if (rd_data == '0 || last_probe) begin
          // Key absent; an empty slot here is where an add goes.
          state_next = S_FIN;
          case (op)
            OP_ADD: begin
              if (count >= m || rd_data != '0) begin
                res_status_next = ST_FULL;
              end else begin
                mem_we           = 1'b1;
                mem_wdata        = key;
                count_next       = count + 1'b1;
                res_present_next = 1'b1;
              end
            end
            OP_REMOVE: begin
              res_status_next = ST_MISSING;
            end
            default: begin
              res_present_next = 1'b0;
            end
          endcase
        end else begin
          n_next     = n + 1'b1;
          pos_next   = pos_inc;
          state_next = S_PROBE_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        // Pull the next cluster key out and find its new slot.
        if (rd_data == '0) begin
          state_next = S_FIN;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = sp;
          rkey_next  = rd_data;
          mod_start  = 1'b1;
          state_next = S_RMOD;
        end
      end
      S_RMOD: begin
        if (mod_done) begin
          pos_next   = AW'(mod_rem);
          state_next = S_PLACE_RD;
        end
      end
      S_PLACE_RD: begin
        state_next = S_PLACE_CHK;
      end
      S_PLACE_CHK: begin
        if (rd_data == '0) begin
          mem_we    = 1'b1;
          mem_wdata = rkey;
          if (last_probe) begin
            state_next = S_FIN;
          end else begin
            n_next     = n + 1'b1;
            sp_next    = sp_inc;
            state_next = S_SCAN_RD;
          end
        end else begin
          pos_next   = pos_inc;
          state_next = S_PLACE_RD;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State register; a register write restarts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      count <= '0;
      slots <= SLOTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      state <= S_CLEAR;
      clr   <= '0;
      count <= '0;
      slots <= cfg_data;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_CLEAR) begin
        clr <= clr + 1'b1;
      end
    end
  end

  // Item datapath registers.
  always_ff @(posedge clk) begin
    op          <= op_next;
    key         <= key_next;
    rkey        <= rkey_next;
    pos         <= pos_next;
    sp          <= sp_next;
    n           <= n_next;
    res_present <= res_present_next;
    res_status  <= res_status_next;
  end

  // Output register holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.present   <= res_present;
      out_item.status    <= res_status;
      out_item.occupancy <= count;
    end
  end

  // The number of held keys never exceeds the modulus.
  assert property (@(posedge clk) disable iff (rst) count <= m)
    else $error("key count exceeds slots in use");

  // An accepted item always leaves the idle state.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> state != S_IDLE)
    else $error("accepted item did not start");

  // A stalled result is kept.
  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result dropped");

endmodule

`default_nettype wire

// ===== dv/lphs_checker.sv =====
// ----------------------------------------------------------------------------
// lphs_checker
// Watches the item, result and modulus channels of the hash set, keeps its
// own copy of the table, and compares every result with the expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_checker #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire lphs_pkg::in_item_t  in_item,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire lphs_pkg::out_item_t out_item,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [10:0]         cfg_data,
  output int                       failures,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lphs_pkg::*;

  // Shadow of the table, the key count and the modulus register.
  logic [63:0] shadow_slots [TABLE_DEPTH];
  int unsigned shadow_count;
  logic [10:0] shadow_modulus;
  out_item_t   expected_results [$];

  function automatic int unsigned active_slots();
    int unsigned m;
    m = shadow_modulus;
    if (m < MIN_SLOTS) m = MIN_SLOTS;
    if (m > TABLE_DEPTH) m = TABLE_DEPTH;
    return m;
  endfunction

  function automatic void empty_table();
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    shadow_count = 0;
  endfunction

  // Slot that holds the key, or -1 when the walk meets a hole or wraps.
  function automatic int find_slot(logic [63:0] key, int unsigned m);
    int unsigned pos;
    pos = int'(key % 64'(m));
    for (int unsigned n = 0; n < m; n++) begin
      if (shadow_slots[pos] == key) return pos;
      if (shadow_slots[pos] == '0) return -1;
      pos = (pos + 1 == m) ? 0 : pos + 1;
    end
    return -1;
  endfunction

  // Put the key into the first hole at or after its home slot.
  function automatic bit store_key(logic [63:0] key, int unsigned m);
    int unsigned pos;
    pos = int'(key % 64'(m));
    for (int unsigned n = 0; n < m; n++) begin
      if (shadow_slots[pos] == '0) begin
        shadow_slots[pos] = key;
        return 1'b1;
      end
      pos = (pos + 1 == m) ? 0 : pos + 1;
    end
    return 1'b0;
  endfunction

  // Applies one item to the shadow table and returns its result.
  function automatic out_item_t apply_item(in_item_t item);
    out_item_t   res;
    int unsigned m;
    int          at;
    int unsigned pos;
    logic [63:0] moved;
    m = active_slots();
    res.present = 1'b0;
    res.status  = ST_OK;
    if (item.key == '0) begin
      res.status = ST_ZERO;
    end else if (item.operation == OP_ADD) begin
      if (find_slot(item.key, m) >= 0) begin
        res.status  = ST_DUP;
        res.present = 1'b1;
      end else if (shadow_count >= m || !store_key(item.key, m)) begin
        res.status = ST_FULL;
      end else begin
        shadow_count++;
        res.present = 1'b1;
      end
    end else if (item.operation == OP_REMOVE) begin
      at = find_slot(item.key, m);
      if (at < 0) begin
        res.status = ST_MISSING;
      end else begin
        shadow_slots[at] = '0;
        if (shadow_count > 0) shadow_count--;
        // Reseat the rest of the cluster so no key sits past a hole.
        for (int unsigned n = 1; n < m; n++) begin
          pos = at + n;
          if (pos >= m) pos -= m;
          moved = shadow_slots[pos];
          if (moved == '0) break;
          shadow_slots[pos] = '0;
          void'(store_key(moved, m));
        end
      end
    end else begin
      // Test, and the spare code three, which decodes as a test.
      res.present = (find_slot(item.key, m) >= 0);
    end
    res.occupancy = 11'(shadow_count);
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("[%0t] result %s mismatch: got %0d, expected %0d", $time, field, got, want);
    failures++;
  endtask

  assign pending = expected_results.size();

  initial failures = 0;

  // Results are compared before the item of the same edge is predicted.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      empty_table();
      shadow_modulus = SLOTS_RESET;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] result transfer with nothing expected", $time);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.present !== want.present)
            report_mismatch("present", out_item.present, want.present);
          if (out_item.status !== want.status)
            report_mismatch("status", out_item.status, want.status);
          if (out_item.occupancy !== want.occupancy)
            report_mismatch("occupancy", out_item.occupancy, want.occupancy);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_item(in_item));
      if (cfg_valid && cfg_ready) begin
        shadow_modulus = cfg_data;
        empty_table();
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/linear_probe_hash_set_top_tb.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_set_top_tb
// Drives add, remove and test items through the hash set under random gaps
// and result stalls, across several modulus settings, and lets the checker
// judge every result.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_set_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lphs_pkg::*;

  localparam int unsigned DEPTH = 1024;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;
  int          failures;
  int          pending;
  bit          no_gaps;

  linear_probe_hash_set_top #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  lphs_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #300ms;
    $display("Some tests failed");
    $finish;
  end

  // Sends one item after a random gap; valid stays up across back-to-back items.
  task automatic send_item(logic [1:0] op, logic [63:0] key);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_item  <= '{operation: op, key: key};
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Rewrites the modulus once every result of the previous phase is back.
  task automatic write_slots(logic [10:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Key whose home slot is the given one, otherwise random in every bit.
  function automatic logic [63:0] key_at_home(int unsigned home, int unsigned m);
    logic [63:0] k;
    k = {$urandom, $urandom};
    k = k - (k % 64'(m)) + 64'(home);
    if (k == '0) k = 64'(m);
    return k;
  endfunction

  // Random phase: a pool of keys, many sharing four home slots.
  task automatic random_phase(int unsigned modulus, int unsigned count);
    logic [63:0] pool [$];
    int unsigned pool_size;
    int unsigned pick;
    int unsigned homes [4];
    logic [1:0]  op;
    logic [63:0] key;
    pool_size = (modulus < 40) ? modulus + 3 : 40;
    foreach (homes[i]) homes[i] = $urandom_range(0, modulus - 1);
    for (int unsigned i = 0; i < pool_size; i++) begin
      if ($urandom_range(0, 1)) pool.push_back({$urandom, $urandom} | 64'd1);
      else pool.push_back(key_at_home(homes[$urandom_range(0, 3)], modulus));
    end
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 45) op = OP_ADD;
      else if (pick < 75) op = OP_REMOVE;
      else if (pick < 97) op = OP_TEST;
      else op = OP_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 2) key = '0;
      else if (pick < 8) key = {$urandom, $urandom};
      else key = pool[$urandom_range(0, pool_size - 1)];
      send_item(op, key);
    end
    no_gaps = 1'b0;
  endtask

  // Result side: a random stall before each result, then ready until it moves.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    no_gaps   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset modulus.
    a = 64'hFFFF_FFFF_FFFF_FFFF;
    send_item(OP_ADD, a);
    send_item(OP_ADD, a);
    send_item(OP_TEST, a);
    send_item(OP_SPARE, a);
    send_item(OP_ADD, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_TEST, '0);
    // A cluster that wraps past the last slot, then removal from its head.
    a = 64'd768;
    b = 64'd768 + 64'd769;
    c = 64'd768 + 64'd1538;
    send_item(OP_ADD, a);
    send_item(OP_ADD, b);
    send_item(OP_ADD, c);
    send_item(OP_ADD, 64'd769);
    send_item(OP_REMOVE, a);
    send_item(OP_TEST, c);
    send_item(OP_REMOVE, b);
    send_item(OP_REMOVE, b);
    send_item(OP_TEST, 64'd769);

    // Smallest table: fill it, then a new key and a duplicate on a full table.
    write_slots(11'd3);
    send_item(OP_ADD, 64'd1);
    send_item(OP_ADD, 64'd4);
    send_item(OP_ADD, 64'd8);
    send_item(OP_ADD, 64'd5);
    send_item(OP_ADD, 64'd4);
    send_item(OP_REMOVE, 64'd1);
    send_item(OP_TEST, 64'd4);

    // Random phases over a spread of register values, extremes included.
    random_phase(3, 120);
    write_slots(11'd2047);
    random_phase(1024, 130);
    write_slots(11'd0);
    random_phase(3, 110);
    write_slots(11'd1024);
    random_phase(1024, 130);
    write_slots(11'd13);
    random_phase(13, 130);
    write_slots(11'd1);
    random_phase(3, 90);
    write_slots(11'd5);
    random_phase(5, 110);
    write_slots(11'd1023);
    random_phase(1023, 120);
    write_slots(11'd769);
    random_phase(769, 110);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
